/* rtl/abia_pkg.sv */
`default_nettype none
package abia_pkg;

  localparam int NumDomains = 16;
  localparam int DomAddrW   = $clog2(NumDomains);
  localparam int DomW       = 4;
  localparam int CountW     = 8;
  localparam int IdW        = 8;
  localparam int CounterW   = 9;
  localparam int LimitW     = 8;
  localparam int StatusW    = 2;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 16;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 32;

  localparam logic [LimitW-1:0] LimitReset = 8'd32;

  typedef enum logic [StatusW-1:0] {
    STAT_GRANT     = 2'd0,
    STAT_ZERO      = 2'd1,
    STAT_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    REG_ID_LIMIT = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } ctrl_state_t;

  typedef struct packed {
    logic load_req;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

/* rtl/abia_ctrl.sv */
`default_nettype none
module abia_ctrl
  import abia_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire dp_status_t dp_status,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.load_req = 1'b0;
    cmd.commit   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_CALC;
        end
      end
      ST_CALC: begin
        if (dp_status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/abia_dp.sv */
`default_nettype none
module abia_dp
  import abia_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd,
  output dp_status_t             dp_status,
  input  wire logic [DomW-1:0]   in_domain_index,
  input  wire logic [CountW-1:0] in_block_count,
  input  wire logic              cfg_we,
  input  wire logic [LimitW-1:0] cfg_wdata,
  output logic [LimitW-1:0]      id_limit,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output status_t                out_status,
  output logic [IdW-1:0]         out_start_id
);

  logic [CounterW-1:0] next_free_r [NumDomains];
  logic [DomW-1:0]     dom_r;
  logic [CountW-1:0]   cnt_r;
  logic [LimitW-1:0]   limit_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [IdW-1:0]      out_start_r;

  logic [CounterW-1:0] cur_raw;
  logic [CounterW-1:0] cur;
  logic [CountW-1:0]   mask;
  logic [CountW-1:0]   m0;
  logic [CountW-1:0]   m1;
  logic [CountW-1:0]   m2;
  logic [CounterW:0]   sum;
  logic [CounterW:0]   aligned;
  logic [CounterW+1:0] run_end;
  logic [CounterW-1:0] pow2;
  logic [CounterW-1:0] counter_nxt;
  logic                dom_ok;
  logic                exhausted;
  status_t             status_nxt;
  logic [IdW-1:0]      start_nxt;

  always_comb begin
    cur_raw = next_free_r[dom_r[DomAddrW-1:0]];
    cur     = (cur_raw == '0) ? CounterW'(1) : cur_raw;
    m0      = cnt_r - CountW'(1);
    m1      = m0 | (m0 >> 1);
    m2      = m1 | (m1 >> 2);
    mask    = m2 | (m2 >> 4);
    pow2    = {1'b0, mask} + CounterW'(1);
    sum     = {1'b0, cur} + (CounterW + 1)'(mask);
    aligned = sum & ~((CounterW + 1)'(mask));
    run_end = {1'b0, aligned} + (CounterW + 2)'(cnt_r);
    dom_ok  = ({1'b0, dom_r} < (DomW + 1)'(NumDomains));
    exhausted = !dom_ok || aligned[CounterW] ||
                (run_end > (CounterW + 2)'(limit_r));
    counter_nxt = aligned[CounterW-1:0] + pow2;
    if (cnt_r == '0) begin
      status_nxt = STAT_ZERO;
      start_nxt  = '0;
    end else if (exhausted) begin
      status_nxt = STAT_EXHAUSTED;
      start_nxt  = '0;
    end else begin
      status_nxt = STAT_GRANT;
      start_nxt  = aligned[IdW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumDomains; i++) begin
        next_free_r[i] <= '0;
      end
    end else if (cmd.commit && (status_nxt == STAT_GRANT)) begin
      next_free_r[dom_r[DomAddrW-1:0]] <= counter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      dom_r <= in_domain_index;
      cnt_r <= in_block_count;
    end
    if (cmd.commit) begin
      out_status_r <= status_nxt;
      out_start_r  <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LimitReset;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign dp_status.out_free = !out_valid_r || out_tready;
  assign id_limit           = limit_r;
  assign out_tvalid         = out_valid_r;
  assign out_status         = out_status_r;
  assign out_start_id       = out_start_r;

endmodule
`default_nettype wire

/* rtl/aligned_block_id_allocator.sv */
// A word accepted in the idle state is held in the request registers; its result is written
// to the output register when the controller commits it, which waits until the output register
// is empty or out_tready is high. No new request is accepted until the last one is committed.
// Reset (synchronous, rst_n low): all domain counters clear to 0 (read as 1),
// id_limit returns to 32, the controller goes idle and the output register empties.
`default_nettype none
module aligned_block_id_allocator
  import abia_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // [3:0] domain_index, [11:4] block_count, [15:12] zero
  input  wire logic [InDataW-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // [1:0] status, [9:2] start_id, [15:10] zero
  output logic [OutDataW-1:0]      out_tdata,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CfgAddrW-1:0] cfg_paddr,
  input  wire logic [CfgDataW-1:0] cfg_pwdata,
  output logic [CfgDataW-1:0]      cfg_prdata,
  output logic                     cfg_pready
);

  ctrl_cmd_t          cmd;
  dp_status_t         dp_status;
  logic               cfg_we;
  logic [LimitW-1:0]  id_limit;
  status_t            out_status;
  logic [IdW-1:0]     out_start_id;
  reg_idx_t           reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[CfgAddrW-1]);
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (reg_sel == REG_ID_LIMIT);

  always_comb begin
    case (reg_sel)
      REG_ID_LIMIT: cfg_prdata = CfgDataW'(id_limit);
      default:      cfg_prdata = '0;
    endcase
  end

  abia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  abia_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .dp_status       (dp_status),
    .in_domain_index (in_tdata[DomW-1:0]),
    .in_block_count  (in_tdata[DomW+CountW-1:DomW]),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_pwdata[LimitW-1:0]),
    .id_limit        (id_limit),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_status      (out_status),
    .out_start_id    (out_start_id)
  );

  assign out_tdata = {(OutDataW - StatusW - IdW)'(0), out_start_id, out_status};

  a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status == STAT_GRANT) |-> (out_start_id != '0))
    else $error("granted block starts at identifier zero");

  a_reject_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_status != STAT_GRANT) |-> (out_start_id == '0))
    else $error("rejected request carries a start identifier");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_status == STAT_GRANT || out_status == STAT_ZERO ||
                    out_status == STAT_EXHAUSTED))
    else $error("undefined status code");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted before the first was committed");

endmodule
`default_nettype wire

/* bench/aligned_block_id_allocator_tb.sv */
`timescale 1ns / 100ps
module aligned_block_id_allocator_tb;
  import abia_pkg::*;

  localparam int IdleLimit = 2000;

  typedef struct {
    status_t        status;
    logic [IdW-1:0] start_id;
  } grant_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [CfgDataW-1:0] cfg_pwdata = '0;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  logic [InDataW-1:0]  pending_requests[$];
  grant_t              awaited_grants[$];
  logic [CounterW-1:0] next_free_id[NumDomains] = '{default: '0};
  logic [LimitW-1:0]   id_limit = LimitReset;
  logic                in_took = 1'b0;
  logic                no_gaps = 1'b0;
  int                  error_count = 0;
  int                  idle_cycles = 0;

  aligned_block_id_allocator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void allocate_ids(input logic [DomW-1:0] domain,
                                       input logic [CountW-1:0] count);
    int unsigned cur;
    int unsigned span;
    int unsigned base;
    grant_t      grant;
    grant.status = STAT_GRANT;
    grant.start_id = '0;
    if (count == 0) begin
      grant.status = STAT_ZERO;
    end else if (int'(domain) >= NumDomains) begin
      grant.status = STAT_EXHAUSTED;
    end else begin
      cur = next_free_id[domain];
      if (cur == 0) begin
        cur = 1;
      end
      span = 1;
      while (span < count) begin
        span = span << 1;
      end
      base = ((cur + span - 1) / span) * span;
      if (base > 511 || base + count > id_limit) begin
        grant.status = STAT_EXHAUSTED;
      end else begin
        next_free_id[domain] = CounterW'(base + span);
        grant.start_id = base[IdW-1:0];
      end
    end
    awaited_grants.insert(awaited_grants.size(), grant);
  endfunction

  task automatic check_grant(input logic [OutDataW-1:0] word);
    grant_t want;
    if (awaited_grants.size() == 0) begin
      report_mismatch("unexpected word", int'(word), -1);
    end else begin
      want = awaited_grants.pop_front();
      if (word[1:0] != want.status) begin
        report_mismatch("status", int'(word[1:0]), int'(want.status));
      end
      if (word[9:2] != want.start_id) begin
        report_mismatch("start_id", int'(word[9:2]), int'(want.start_id));
      end
      if (word[15:10] != '0) begin
        report_mismatch("padding", int'(word[15:10]), 0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
      idle_cycles = 0;
    end else begin
      in_took = in_tvalid && in_tready;
      if (in_took) begin
        allocate_ids(in_tdata[3:0], in_tdata[11:4]);
      end
      if (out_tvalid && out_tready) begin
        check_grant(out_tdata);
      end
      if (in_took || (out_tvalid && out_tready) || cfg_psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_took) begin
        if (pending_requests.size() != 0 && (no_gaps || $urandom_range(99) >= 12)) begin
          in_tdata <= pending_requests.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tdata <= InDataW'($urandom);
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= no_gaps || ($urandom_range(99) >= 12);
    end
  end

  task automatic post_request(input int domain, input int count);
    pending_requests.insert(pending_requests.size(),
                            {4'b0, CountW'(count), DomW'(domain)});
  endtask

  task automatic post_random_requests(input int n);
    int pick;
    int count;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        count = 0;
      end else if (pick < 80) begin
        count = $urandom_range(3, 1);
      end else if (pick < 95) begin
        count = $urandom_range(16, 4);
      end else begin
        count = $urandom_range(255, 0);
      end
      post_request($urandom_range(NumDomains - 1), count);
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_requests.size() != 0 || in_tvalid || awaited_grants.size() != 0);
  endtask

  task automatic write_id_limit(input logic [LimitW-1:0] value);
    logic [CfgDataW-1:0] readback;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CfgAddrW'(4 * int'(REG_ID_LIMIT));
    cfg_pwdata <= ($urandom & ~32'hFF) | CfgDataW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback[LimitW-1:0] != value) begin
      report_mismatch("id_limit readback", int'(readback[LimitW-1:0]), int'(value));
    end
    id_limit = value;
  endtask

  initial begin
    int unsigned limits[6] = '{0, 1, 160, 100, 255, 64};
    int unsigned sizes[6] = '{40, 40, 300, 250, 500, 170};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Fresh counters read as one, alignment, the limit edge and back-to-back requests.
    post_request(0, 1);
    post_request(0, 0);
    post_request(0, 3);
    post_request(0, 1);
    post_request(0, 16);
    post_request(0, 1);
    post_request(15, 255);
    post_request(15, 32);
    post_request(15, 31);
    post_request(1, 17);
    post_request(1, 128);
    post_request(2, 170);
    post_request(5, 85);
    post_request(3, 1);
    post_request(3, 1);
    post_request(3, 1);
    post_request(3, 1);
    post_request(3, 2);
    post_request(10, 1);
    post_request(5, 0);
    post_request(7, 8);
    post_random_requests(200);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      write_id_limit(LimitW'(limits[phase]));
      if (limits[phase] == 255) begin
        no_gaps = 1'b1;
        post_request(14, 127);
        post_request(14, 1);
        post_request(14, 0);
      end
      post_random_requests(sizes[phase]);
      wait_drained();
      no_gaps = 1'b0;
    end

    repeat (8) @(negedge clk);
    if (awaited_grants.size() != 0) begin
      report_mismatch("words still awaited", awaited_grants.size(), 0);
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
